@@ rtl/core/slid_pkg.sv @@
package slid_pkg;

  // List depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int ENTRY_W  = 5;
  localparam int STAT_W   = 2;

  // Operation codes on the func port
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_DELETE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DELETED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // Command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // What a cell shows its right-hand neighbor
  typedef struct packed {
    logic                    gt;
    logic signed [VAL_W-1:0] value;
  } link_t;

endpackage

@@ rtl/core/slid_cell.sv @@
module slid_cell (
  input  logic                                     clk,
  input  slid_pkg::cmd_t                           cmd,
  input  logic                                     occ,
  input  slid_pkg::link_t                          left,
  input  logic signed [slid_pkg::VAL_W-1:0]        right_value,
  output slid_pkg::link_t                          link,
  output logic                                     eq
);

  logic signed [slid_pkg::VAL_W-1:0] value;
  logic signed [slid_pkg::VAL_W-1:0] value_next;
  logic                              gt;

  // Compare the stored value against the broadcast request value
  assign gt = occ && (value > cmd.value);
  assign eq = occ && (value == cmd.value);

  assign link.gt    = gt;
  assign link.value = value;

  // Pick the new content: keep, take the request value, or shift from a neighbor
  always_comb begin
    value_next = value;
    if (cmd.ins && !gt) begin
      if (left.gt) begin
        value_next = cmd.value;
      end else begin
        value_next = left.value;
      end
    end else if (cmd.del && !gt) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ rtl/core/sorted_list_insert_delete_top.sv @@
// Latency: the result strobe done rises in the cycle after the request is taken.
// Throughput: one request per cycle while busy is low; every cell compares and shifts
// in parallel, so the whole chain of cells updates together on an insert or delete.
// busy is high during reset and clears once reset is released; no clearing pass is needed.
// Reset empties the list (count to zero); stored values stay unknown until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_list_insert_delete_top (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  output logic                                       busy,
  input  logic                                       func,
  input  logic signed [slid_pkg::VAL_W-1:0]          value,
  output logic                                       done,
  output logic [slid_pkg::STAT_W-1:0]                status,
  output logic signed [slid_pkg::VAL_W-1:0]          head_value,
  output logic [slid_pkg::ENTRY_W-1:0]               entry_count,
  output logic                                       is_empty
);

  logic [slid_pkg::CNT_W-1:0]       count;
  logic [slid_pkg::CNT_W-1:0]       count_next;
  logic [slid_pkg::STAT_W-1:0]      status_next;
  logic                             accept;
  logic                             full;
  logic                             found;
  slid_pkg::cmd_t                   cmd;
  slid_pkg::link_t                  links [slid_pkg::CAPACITY];
  logic [slid_pkg::CAPACITY-1:0]    eq_vec;
  logic [slid_pkg::CAPACITY-1:0]    occ_vec;

  assign accept = start && !busy;
  assign full   = (count == slid_pkg::CNT_W'(slid_pkg::CAPACITY));
  assign found  = |eq_vec;

  // Build the request broadcast to the cells
  always_comb begin
    cmd.value = value;
    cmd.ins   = accept && (func == slid_pkg::FN_INSERT) && !full;
    cmd.del   = accept && (func == slid_pkg::FN_DELETE) && found;
  end

  // Row of cells, head at index zero
  for (genvar i = 0; i < slid_pkg::CAPACITY; i++) begin : g_cell
    slid_pkg::link_t                   left_link;
    logic signed [slid_pkg::VAL_W-1:0] right_val;

    assign occ_vec[i] = (slid_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_link.gt    = 1'b1;
      assign left_link.value = value;
    end else begin : g_body
      assign left_link = links[i-1];
    end

    if (i == slid_pkg::CAPACITY - 1) begin : g_tail
      assign right_val = links[i].value;
    end else begin : g_mid
      assign right_val = links[i+1].value;
    end

    slid_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ_vec[i]),
      .left        (left_link),
      .right_value (right_val),
      .link        (links[i]),
      .eq          (eq_vec[i])
    );
  end

  // Work out the new count and the status of this request
  always_comb begin
    count_next  = count;
    status_next = slid_pkg::ST_NOT_FOUND;
    if (func == slid_pkg::FN_INSERT) begin
      if (full) begin
        status_next = slid_pkg::ST_FULL;
      end else begin
        status_next = slid_pkg::ST_INSERTED;
      end
    end else if (found) begin
      status_next = slid_pkg::ST_DELETED;
    end
    if (cmd.ins) begin
      count_next = count + slid_pkg::CNT_W'(1);
    end else if (cmd.del) begin
      count_next = count - slid_pkg::CNT_W'(1);
    end
  end

  // Hold count, strobe and status
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done   <= 1'b0;
      busy   <= 1'b1;
      status <= slid_pkg::ST_INSERTED;
    end else begin
      busy  <= 1'b0;
      count <= count_next;
      done  <= accept;
      if (accept) begin
        status <= status_next;
      end
    end
  end

  // Drive the result fields from the updated list
  assign is_empty    = (count == '0);
  assign head_value  = is_empty ? '0 : links[0].value;
  assign entry_count = slid_pkg::ENTRY_W'(count);

  a_done_after_accept : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without a taken request");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= slid_pkg::CNT_W'(slid_pkg::CAPACITY))
    else $error("count above capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (done && status == slid_pkg::ST_INSERTED) |->
      count == slid_pkg::CNT_W'($past(count) + slid_pkg::CNT_W'(1)))
    else $error("insert did not grow the list by one");

  a_delete_shrinks : assert property (@(posedge clk) disable iff (rst)
    (done && status == slid_pkg::ST_DELETED) |->
      count == slid_pkg::CNT_W'($past(count) - slid_pkg::CNT_W'(1)))
    else $error("delete did not shrink the list by one");

  a_full_holds : assert property (@(posedge clk) disable iff (rst)
    (done && status == slid_pkg::ST_FULL) |->
      (count == slid_pkg::CNT_W'(slid_pkg::CAPACITY)) && $stable(count))
    else $error("dropped insert changed the list");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int NUM_RANDOM = 800;
  localparam int MAX_GAP    = 13;
  localparam int CYCLE_LIMIT = 100000;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              func = slid_pkg::FN_INSERT;
  logic signed [slid_pkg::VAL_W-1:0] value = '0;
  logic                              busy;
  logic                              done;
  logic [slid_pkg::STAT_W-1:0]       status;
  logic signed [slid_pkg::VAL_W-1:0] head_value;
  logic [slid_pkg::ENTRY_W-1:0]      entry_count;
  logic                              is_empty;

  int cycles = 0;

  // One result of the list as seen on the result ports
  typedef struct {
    logic [slid_pkg::STAT_W-1:0]       status;
    logic signed [slid_pkg::VAL_W-1:0] head;
    logic [slid_pkg::ENTRY_W-1:0]      count;
    logic                              empty;
  } outcome_t;

  // Shadow copy of the sorted list plus the outcomes still owed by the block
  class list_scoreboard;
    logic signed [slid_pkg::VAL_W-1:0] shelf[$];
    outcome_t                          due_outcomes[$];
    int errors;
    int checked;
    int n_added;
    int n_dropped;
    int n_removed;
    int n_missed;

    // Apply one accepted request to the shadow list and queue its outcome
    function void take_request(logic fn, logic signed [slid_pkg::VAL_W-1:0] v);
      outcome_t o;
      int       pos;
      pos = 0;
      if (fn == slid_pkg::FN_INSERT) begin
        if (shelf.size() >= slid_pkg::CAPACITY) begin
          o.status = slid_pkg::ST_FULL;
          n_dropped++;
        end else begin
          // place ahead of the first value that is not greater
          while (pos < shelf.size() && shelf[pos] > v) pos++;
          shelf.insert(pos, v);
          o.status = slid_pkg::ST_INSERTED;
          n_added++;
        end
      end else begin
        while (pos < shelf.size() && shelf[pos] != v) pos++;
        if (pos >= shelf.size()) begin
          o.status = slid_pkg::ST_NOT_FOUND;
          n_missed++;
        end else begin
          shelf.delete(pos);
          o.status = slid_pkg::ST_DELETED;
          n_removed++;
        end
      end
      o.head  = (shelf.size() > 0) ? shelf[0] : '0;
      o.count = slid_pkg::ENTRY_W'(shelf.size());
      o.empty = (shelf.size() == 0);
      due_outcomes.push_back(o);
    endfunction

    // Compare one strobed result against the oldest owed outcome
    function void check_result(logic [slid_pkg::STAT_W-1:0] st,
                               logic signed [slid_pkg::VAL_W-1:0] hd,
                               logic [slid_pkg::ENTRY_W-1:0] cnt, logic emp);
      outcome_t o;
      if (due_outcomes.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d head %0d count %0d empty %0b",
                 $time, st, hd, cnt, emp);
        errors++;
        return;
      end
      o = due_outcomes.pop_front();
      checked++;
      if (st !== o.status) begin
        $display("%0t: status expected %0d actual %0d", $time, o.status, st);
        errors++;
      end
      if (hd !== o.head) begin
        $display("%0t: head_value expected %0d actual %0d", $time, o.head, hd);
        errors++;
      end
      if (cnt !== o.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, o.count, cnt);
        errors++;
      end
      if (emp !== o.empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time, o.empty, emp);
        errors++;
      end
    endfunction
  endclass

  list_scoreboard board;

  sorted_list_insert_delete_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .value      (value),
    .done       (done),
    .status     (status),
    .head_value (head_value),
    .entry_count(entry_count),
    .is_empty   (is_empty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Check results first, then note the request taken at this edge
  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (done) board.check_result(status, head_value, entry_count, is_empty);
      if (start && !busy) board.take_request(func, value);
    end
  end

  // Idle for gap cycles, then hold the request until the block takes it
  task automatic send(input logic fn, input logic signed [slid_pkg::VAL_W-1:0] v,
                      input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func  <= fn;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int                                i;
    int                                gap;
    int                                insert_bias;
    bit                                burst;
    logic                              fn;
    logic signed [slid_pkg::VAL_W-1:0] v;

    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty delete, extremes, duplicates, fill to full, drop on full
    send(slid_pkg::FN_DELETE, 32'sd7, $urandom_range(0, MAX_GAP));
    send(slid_pkg::FN_INSERT, 32'sh7fffffff, 0);
    send(slid_pkg::FN_INSERT, 32'sh80000000, $urandom_range(0, MAX_GAP));
    send(slid_pkg::FN_INSERT, 32'sd0, 0);
    send(slid_pkg::FN_INSERT, -32'sd1, 0);
    send(slid_pkg::FN_INSERT, 32'sd0, $urandom_range(0, MAX_GAP));
    send(slid_pkg::FN_DELETE, 32'sd0, 0);
    send(slid_pkg::FN_DELETE, 32'sh80000000, 0);
    send(slid_pkg::FN_DELETE, 32'sd5, $urandom_range(0, MAX_GAP));
    for (i = 0; i < slid_pkg::CAPACITY - 2; i++) begin
      v = $urandom;
      send(slid_pkg::FN_INSERT, v, (i % 3 == 0) ? $urandom_range(0, MAX_GAP) : 0);
    end
    send(slid_pkg::FN_INSERT, 32'sd3, 0);
    send(slid_pkg::FN_DELETE, 32'sh7fffffff, 0);

    // Random: pools of small values and stored values keep hits and ties common
    insert_bias = 50;
    burst = 1'b0;
    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i % 64 == 0) begin
        burst       = ($urandom_range(0, 2) == 0);
        insert_bias = $urandom_range(25, 80);
      end
      fn = ($urandom_range(0, 99) < insert_bias) ? slid_pkg::FN_INSERT : slid_pkg::FN_DELETE;
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          v = $urandom_range(0, 8);
          v = v - 4;
        end
        3, 4: begin
          if (board.shelf.size() > 0)
            v = board.shelf[$urandom_range(0, board.shelf.size() - 1)];
          else
            v = $urandom;
        end
        5: begin
          case ($urandom_range(0, 3))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = 32'sd0;
            default: v = -32'sd1;
          endcase
        end
        default: v = $urandom;
      endcase
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      send(fn, v, gap);
    end
    start <= 1'b0;

    // Drain owed results, then wait on so that stray strobes are still caught
    while (board.due_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d requests: %0d inserts stored, %0d dropped on a full list",
             board.checked, board.n_added, board.n_dropped);
    $display("Deletes: %0d removed, %0d not found; %0d mismatches",
             board.n_removed, board.n_missed, board.errors);
    if (board.errors == 0 && board.due_outcomes.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
